### rtl/shash_pkg.sv
// shared types and constants for the streaming sha-256 hasher
// no dependencies; used by shash_ctrl, shash_dp and sha256_stream_hasher
`default_nettype none

package shash_pkg;

  // source of the byte shifted into the message block
  typedef enum logic [1:0] {
    SEL_MSG  = 2'd0,
    SEL_PAD  = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic        load_byte;
    byte_sel_t   byte_sel;
    logic [2:0]  len_idx;
    logic        count_byte;
    logic        work_init;
    logic        round_en;
    logic [5:0]  round_idx;
    logic        chain_add;
    logic        digest_load;
  } shash_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic obuf_busy;
  } shash_stat_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

endpackage

`default_nettype wire

### rtl/shash_ctrl.sv
// control state machine of the sha-256 hasher: byte fill, padding, rounds
// depends on shash_pkg (command and status structs)
`default_nettype none

module shash_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_byte_valid,
  input  wire logic                   in_last,
  output shash_pkg::shash_cmd_t       cmd,
  input  wire shash_pkg::shash_stat_t status
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PAD  = 6'b000010,
    ST_LEN  = 6'b000100,
    ST_COMP = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  localparam logic [5:0] FILL_LAST   = 6'd63;
  localparam logic [5:0] FILL_PRELEN = 6'd55;
  localparam logic [5:0] ROUND_LAST  = 6'd63;

  state_t     state_r, state_nxt;
  state_t     resume_r, resume_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic [5:0] round_r, round_nxt;
  logic       pad_first_r, pad_first_nxt;

  always_comb begin
    state_nxt     = state_r;
    resume_nxt    = resume_r;
    fill_nxt      = fill_r;
    round_nxt     = round_r;
    pad_first_nxt = pad_first_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.byte_sel  = shash_pkg::SEL_MSG;
    cmd.len_idx   = fill_r[2:0];
    cmd.round_idx = round_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pad_first_nxt = 1'b1;
          if (in_byte_valid) begin
            cmd.load_byte  = 1'b1;
            cmd.count_byte = 1'b1;
            fill_nxt       = fill_r + 6'd1;
          end
          if (in_byte_valid && fill_r == FILL_LAST) begin
            cmd.work_init = 1'b1;
            state_nxt     = ST_COMP;
            resume_nxt    = in_last ? ST_PAD : ST_IDLE;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.load_byte = 1'b1;
        cmd.byte_sel  = pad_first_r ? shash_pkg::SEL_PAD : shash_pkg::SEL_ZERO;
        pad_first_nxt = 1'b0;
        fill_nxt      = fill_r + 6'd1;
        if (fill_r == FILL_LAST) begin
          cmd.work_init = 1'b1;
          state_nxt     = ST_COMP;
          resume_nxt    = ST_PAD;
        end else if (fill_r == FILL_PRELEN) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        cmd.load_byte = 1'b1;
        cmd.byte_sel  = shash_pkg::SEL_LEN;
        fill_nxt      = fill_r + 6'd1;
        if (fill_r == FILL_LAST) begin
          cmd.work_init = 1'b1;
          state_nxt     = ST_COMP;
          resume_nxt    = ST_DONE;
        end
      end
      ST_COMP: begin
        cmd.round_en = 1'b1;
        round_nxt    = round_r + 6'd1;
        if (round_r == ROUND_LAST) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.chain_add = 1'b1;
        state_nxt     = resume_r;
      end
      ST_DONE: begin
        if (!status.obuf_busy) begin
          cmd.digest_load = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      resume_r    <= ST_IDLE;
      fill_r      <= '0;
      round_r     <= '0;
      pad_first_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      resume_r    <= resume_nxt;
      fill_r      <= fill_nxt;
      round_r     <= round_nxt;
      pad_first_r <= pad_first_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP && round_r == ROUND_LAST) |=> state_r == ST_FIN)
    else $error("compression did not end after the last round");

  a_round_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_COMP |-> round_r == 6'd0)
    else $error("round counter not cleared outside compression");

  a_fill_comp: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_COMP |-> fill_r == 6'd0)
    else $error("compression started on a partly filled block");

  a_len_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LEN |-> fill_r[5:3] == 3'b111)
    else $error("length bytes outside the last eight block bytes");
`endif

endmodule

`default_nettype wire

### rtl/shash_dp.sv
// datapath of the sha-256 hasher: message block, round logic, chain and digest buffer
// depends on shash_pkg (constants, command and status structs)
`default_nettype none

module shash_dp (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [7:0]             in_data_byte,
  input  wire shash_pkg::shash_cmd_t  cmd,
  output shash_pkg::shash_stat_t      status,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [31:0]                 out_digest_word,
  output logic [2:0]                  out_word_index,
  output logic                        out_last_word
);

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sml_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sml_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  // message block, word 0 in the top bits; doubles as schedule window
  logic [511:0] blk_r;
  logic [31:0]  work_r [8];
  logic [31:0]  chain_r [8];
  logic [60:0]  total_r;
  logic [31:0]  obuf_r [8];
  logic         busy_r;
  logic [2:0]   idx_r;

  logic [7:0]   byte_in;
  logic [63:0]  len_bits;
  logic [31:0]  w_new;
  logic [31:0]  t1;
  logic [31:0]  t2;

  assign len_bits = {total_r, 3'b000} << {cmd.len_idx, 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      shash_pkg::SEL_MSG:  byte_in = in_data_byte;
      shash_pkg::SEL_PAD:  byte_in = shash_pkg::PAD_BYTE;
      shash_pkg::SEL_ZERO: byte_in = 8'h00;
      shash_pkg::SEL_LEN:  byte_in = len_bits[63:56];
      default:             byte_in = 8'h00;
    endcase
  end

  // window words: w0 = [511:480], w1 = [479:448], w9 = [223:192], w14 = [63:32]
  assign w_new = sml_s1(blk_r[63:32]) + blk_r[223:192] + sml_s0(blk_r[479:448])
               + blk_r[511:480];

  assign t1 = work_r[7] + big_s1(work_r[4])
            + ((work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]))
            + shash_pkg::ROUND_K[cmd.round_idx] + blk_r[511:480];
  assign t2 = big_s0(work_r[0])
            + ((work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]));

  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      blk_r <= {blk_r[503:0], byte_in};
    end else if (cmd.round_en) begin
      blk_r <= {blk_r[479:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.work_init) begin
      for (int i = 0; i < 8; i++) work_r[i] <= chain_r[i];
    end else if (cmd.round_en) begin
      work_r[7] <= work_r[6];
      work_r[6] <= work_r[5];
      work_r[5] <= work_r[4];
      work_r[4] <= work_r[3] + t1;
      work_r[3] <= work_r[2];
      work_r[2] <= work_r[1];
      work_r[1] <= work_r[0];
      work_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) chain_r[i] <= shash_pkg::INIT_HASH[i];
      total_r <= '0;
    end else begin
      if (cmd.chain_add) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= chain_r[i] + work_r[i];
      end else if (cmd.digest_load) begin
        for (int i = 0; i < 8; i++) chain_r[i] <= shash_pkg::INIT_HASH[i];
      end
      if (cmd.digest_load) begin
        total_r <= '0;
      end else if (cmd.count_byte) begin
        total_r <= total_r + 61'd1;
      end
    end
  end

  // digest buffer drains word 0 first
  always_ff @(posedge clk) begin
    if (cmd.digest_load) begin
      for (int i = 0; i < 8; i++) obuf_r[i] <= chain_r[i];
    end else if (out_valid && out_ready) begin
      for (int i = 0; i < 7; i++) obuf_r[i] <= obuf_r[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (cmd.digest_load) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (out_valid && out_ready) begin
      idx_r <= idx_r + 3'd1;
      if (idx_r == 3'd7) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign status.obuf_busy = busy_r;
  assign out_valid        = busy_r;
  assign out_digest_word  = obuf_r[0];
  assign out_word_index   = idx_r;
  assign out_last_word    = (idx_r == 3'd7);

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.digest_load |-> !busy_r)
    else $error("digest loaded over an undrained buffer");

  a_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.round_en |-> !cmd.load_byte && !cmd.count_byte)
    else $error("byte load during a compression round");
`endif

endmodule

`default_nettype wire

### rtl/sha256_stream_hasher.sv
// top level of the streaming sha-256 hasher
// depends on shash_pkg, shash_ctrl and shash_dp
`default_nettype none

// usage
//  - input channel (in_valid/in_ready): one beat per message byte; in_byte_valid
//    marks a real byte, in_last ends the message (a byte on the same beat is
//    taken first); in_last with no byte on a message's only beat hashes an empty message
//  - result channel (out_valid/out_ready): eight beats per message, digest
//    words 0..7 most significant first, out_last_word on word 7
//  - throughput: one byte beat per cycle while a block fills; the 64th byte
//    starts 64 rounds at one per cycle followed by a chaining add; in_ready
//    is low while the round unit is busy
//  - end of message: one padding byte per cycle up to byte 56, eight length
//    bytes, then the rounds and chaining add per final block (one or two
//    blocks), then a copy into the digest buffer once the buffer is free
//  - the digest sits in an eight-word output buffer, so the next message is
//    taken while the receiver stalls; only a second digest waits for the
//    buffer to drain
//  - reset (rst_n low, synchronous): chaining words back to the initial hash
//    value, length and fill counters cleared, buffer emptied; no sweep needed

module sha256_stream_hasher (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_byte_valid,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  // controller drives the datapath only through these two structs
  shash_pkg::shash_cmd_t  cmd;
  shash_pkg::shash_stat_t status;

  shash_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte_valid (in_byte_valid),
    .in_last       (in_last),
    .cmd           (cmd),
    .status        (status)
  );

  // message block, round logic, chaining words and digest buffer
  shash_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

`default_nettype wire

### verif/tb_sha256_stream_hasher.sv
// self-checking testbench for the streaming sha-256 hasher: directed and random byte streams in,
// digest words checked against an in-bench sha-256 predictor
// depends on rtl/shash_pkg.sv and rtl/sha256_stream_hasher.sv
`timescale 1ns / 100ps

module tb_sha256_stream_hasher;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned IDLE_PCT = 13;

  // round constants and initial hash value, kept apart from the rtl copies
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_SLOT = 6'd56;

  // one input beat as queued for the driver
  typedef struct packed {
    logic [7:0] data;
    logic       byte_valid;
    logic       last;
  } msg_beat_t;

  // one digest word as it should leave the block
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_beat_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_valid = 1'b0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_stream_hasher u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_byte_valid   (in_byte_valid),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // hash state of the predictor: chaining words, block being filled,
  // byte position in the block and message length in bytes
  // ---------------------------------------------------------------------
  logic [31:0] chain_h [8];
  logic [31:0] blk_w [16];
  logic [5:0]  blk_pos;
  logic [60:0] msg_len;

  msg_beat_t    beats_pending [$];
  digest_beat_t digest_words_due [$];

  int  mismatches = 0;
  int  beats_taken = 0;
  int  counted_beats = 0;
  logic beat_taken = 1'b0;
  logic quiet_span;

  // both sides stop idling for a stretch in the middle of the random part
  assign quiet_span = (beats_taken >= 60) && (beats_taken < 130);

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // 64 rounds over the current block, schedule expanded in place
  task automatic sha_rounds();
    logic [31:0] v [8];
    logic [31:0] x15, x2, sg0, sg1, wt, ep1, chv, t1, ep0, mj;
    for (int j = 0; j < 8; j++) v[j] = chain_h[j];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        x15 = blk_w[(t + 1) & 15];
        x2  = blk_w[(t + 14) & 15];
        sg0 = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
        sg1 = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
        blk_w[t & 15] = blk_w[t & 15] + sg0 + blk_w[(t + 9) & 15] + sg1;
      end
      wt  = blk_w[t & 15];
      ep1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      chv = (v[4] & v[5]) ^ (~v[4] & v[6]);
      t1  = v[7] + ep1 + chv + SHA_K[t] + wt;
      ep0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      mj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + ep0 + mj;
    end
    for (int j = 0; j < 8; j++) chain_h[j] = chain_h[j] + v[j];
  endtask

  // big-endian byte packing; a full block triggers compression
  task automatic absorb_byte(logic [7:0] b);
    logic [3:0] wsel;
    int unsigned sh;
    wsel = blk_pos[5:2];
    sh = 24 - 8 * blk_pos[1:0];
    if (blk_pos[1:0] == 2'd0) blk_w[wsel] = 32'h0;
    blk_w[wsel] = blk_w[wsel] | (32'(b) << sh);
    blk_pos = blk_pos + 6'd1;
    if (blk_pos == 6'd0) sha_rounds();
  endtask

  // one accepted beat: absorb the byte, and on last pad, finish and queue the digest
  task automatic sha_take_beat(logic [7:0] data, logic bv, logic lst);
    logic [63:0] bit_len;
    digest_beat_t d;
    if (bv) begin
      absorb_byte(data);
      msg_len = msg_len + 61'd1;
    end
    if (lst) begin
      bit_len = {msg_len, 3'b000};
      absorb_byte(PAD_MARK);
      while (blk_pos != LEN_SLOT) absorb_byte(8'h00);
      blk_w[14] = bit_len[63:32];
      blk_w[15] = bit_len[31:0];
      sha_rounds();
      for (int j = 0; j < 8; j++) begin
        d.word = chain_h[j];
        d.idx  = 3'(j);
        d.fin  = (j == 7);
        digest_words_due.push_back(d);
      end
      for (int j = 0; j < 8; j++) chain_h[j] = SHA_IV[j];
      msg_len = '0;
      blk_pos = '0;
    end
  endtask

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  task automatic queue_beat(logic [7:0] data, logic bv, logic lst);
    msg_beat_t b;
    b.data = data;
    b.byte_valid = bv;
    b.last = lst;
    beats_pending.push_back(b);
    if (bv || lst) counted_beats++;
  endtask

  // random message of len bytes; the last byte may share the beat with last,
  // idle beats sprinkled in as noise
  task automatic queue_message(int len);
    logic on_last;
    on_last = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8) queue_beat(8'($urandom), 1'b0, 1'b0);
      queue_beat(8'($urandom), 1'b1, on_last && (i == len - 1));
    end
    if (!on_last) queue_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  function automatic int pick_length();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(0, 8);
      5, 6:          return $urandom_range(9, 40);
      // padding fits in one block at 55, spills into a second block at 56
      7:             return $urandom_range(55, 56);
      // one byte under a block, exactly one block, one over
      8:             return $urandom_range(63, 65);
      default:       return $urandom_range(119, 120);
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // mismatch reporting
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // driver: presents the next pending beat at the falling edge once the
  // previous one is taken, with random idle cycles outside the quiet span
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : drive_in
    msg_beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_taken) begin
      if (beats_pending.size() != 0 &&
          (quiet_span || $urandom_range(0, 99) >= IDLE_PCT)) begin
        nxt = beats_pending.pop_front();
        in_valid      <= 1'b1;
        in_data_byte  <= nxt.data;
        in_byte_valid <= nxt.byte_valid;
        in_last       <= nxt.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stalls at random, never during the quiet span
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_span || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------
  // monitor: sample both handshakes at the rising edge; an input beat
  // feeds the predictor, an output beat is checked against the oldest
  // digest word still due
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : watch
    digest_beat_t want;
    if (!rst_n) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        sha_take_beat(in_data_byte, in_byte_valid, in_last);
        beats_taken++;
      end
      if (out_valid && out_ready) begin
        if (digest_words_due.size() == 0) begin
          report_mismatch("unexpected digest beat", out_digest_word, 32'h0);
        end else begin
          want = digest_words_due.pop_front();
          if (out_digest_word !== want.word)
            report_mismatch($sformatf("digest word %0d", want.idx), out_digest_word, want.word);
          if (out_word_index !== want.idx)
            report_mismatch("word index", 32'(out_word_index), 32'(want.idx));
          if (out_last_word !== want.fin)
            report_mismatch("last word flag", 32'(out_last_word), 32'(want.fin));
        end
      end
    end
  end

  // watchdog on total run length
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    for (int j = 0; j < 8; j++) chain_h[j] = SHA_IV[j];
    for (int j = 0; j < 16; j++) blk_w[j] = 32'h0;
    blk_pos = '0;
    msg_len = '0;

    // directed part
    queue_beat(8'h00, 1'b0, 1'b0);        // idle beats, ignored
    queue_beat(8'hff, 1'b0, 1'b0);
    queue_beat(8'hff, 1'b0, 1'b1);        // empty message
    queue_beat(8'h00, 1'b0, 1'b1);        // empty message again, back to back
    queue_beat(8'h00, 1'b1, 1'b1);        // single byte on the last beat
    queue_beat(8'hff, 1'b1, 1'b0);        // single byte, last on its own beat
    queue_beat(8'h00, 1'b0, 1'b1);
    queue_beat(8'h61, 1'b1, 1'b0);        // "abc"
    queue_beat(8'h62, 1'b1, 1'b0);
    queue_beat(8'h63, 1'b1, 1'b1);
    queue_beat(8'ha5, 1'b1, 1'b0);        // idle beat inside a message
    queue_beat(8'hff, 1'b0, 1'b0);
    queue_beat(8'h5a, 1'b1, 1'b0);
    queue_beat(8'h7e, 1'b0, 1'b1);

    // random messages
    counted_beats = 0;
    while (counted_beats < 130) queue_message(pick_length());

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every beat accepted, then every digest word out
    while (beats_pending.size() != 0 || in_valid) @(posedge clk);
    while (digest_words_due.size() != 0) @(posedge clk);
    // catch stray digest beats
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sim.f
rtl/shash_pkg.sv
rtl/shash_ctrl.sv
rtl/shash_dp.sv
rtl/sha256_stream_hasher.sv
verif/tb_sha256_stream_hasher.sv
